FILE: hw/rtl/pps_pkg.sv
package pps_pkg;

  // default width of the bound field
  localparam int BOUND_BITS_DEF = 16;

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_DIV,
    ST_EVAL,
    ST_DONE
  } pps_state_t;

endpackage

FILE: hw/rtl/pps_in_if.sv
interface pps_in_if #(
  parameter int BOUND_BITS = pps_pkg::BOUND_BITS_DEF
);
  logic                  valid;
  logic                  ready;
  logic [BOUND_BITS-1:0] lower_bound;

  modport source (output valid, output lower_bound, input ready);
  modport sink   (input valid, input lower_bound, output ready);
endinterface

FILE: hw/rtl/pps_out_if.sv
interface pps_out_if #(
  parameter int BOUND_BITS = pps_pkg::BOUND_BITS_DEF
);
  logic                valid;
  logic                ready;
  logic [BOUND_BITS:0] paley_order;
  logic                bound_is_order;

  modport source (output valid, output paley_order, output bound_is_order, input ready);
  modport sink   (input valid, input paley_order, input bound_is_order, output ready);
endinterface

FILE: hw/rtl/paley_prime_order_search_top.sv
// channel  dir  beat payload
// -------  ---  -----------------------------------------
// req      in   lower_bound [BOUND_BITS-1:0]
// rsp      out  paley_order [BOUND_BITS:0], bound_is_order
//
// one item at a time; req.ready is high only while the sequencer is idle
// each trial divisor takes one square compare, BOUND_BITS+1
// restoring remainder steps on the shared compare/subtract unit, and one update
// rst is synchronous and returns the sequencer to idle; the result is held until rsp.ready
module paley_prime_order_search_top #(
  parameter int BOUND_BITS = pps_pkg::BOUND_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst,
  pps_in_if.sink     req,
  pps_out_if.source  rsp
);
  import pps_pkg::*;

  localparam int OUT_W = BOUND_BITS + 1;
  localparam int SQ_W  = OUT_W + 1;
  localparam int IDX_W = $clog2(OUT_W);

  pps_state_t state, state_next;

  logic [BOUND_BITS-1:0] bound;
  logic [OUT_W-1:0]      cand;
  logic [OUT_W-1:0]      d;
  logic [SQ_W-1:0]       sq;
  logic [OUT_W-1:0]      rem;
  logic [IDX_W-1:0]      idx;

  logic                  sq_over;
  logic [OUT_W:0]        trial;
  logic                  trial_ge;
  logic [OUT_W-1:0]      rem_step;

  // shared compare/subtract unit: one restoring remainder step
  always_comb begin
    trial    = {rem, cand[idx]};
    trial_ge = (trial >= {1'b0, d});
    rem_step = trial_ge ? OUT_W'(trial - {1'b0, d}) : trial[OUT_W-1:0];
  end

  // divisor squared beyond candidate means no divisor left
  assign sq_over = (sq > {1'b0, cand});

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:  if (req.valid) state_next = ST_CHECK;
      ST_CHECK: state_next = sq_over ? ST_DONE : ST_DIV;
      ST_DIV:   if (idx == '0) state_next = ST_EVAL;
      ST_EVAL:  state_next = ST_CHECK;
      ST_DONE:  if (rsp.ready) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  // handshake outputs
  always_comb begin
    req.ready = (state == ST_IDLE);
    rsp.valid = (state == ST_DONE);
  end

  assign rsp.paley_order    = cand;
  assign rsp.bound_is_order = (cand == {1'b0, bound});

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (req.valid) begin
          bound <= req.lower_bound;
          cand  <= (({1'b0, req.lower_bound} + OUT_W'(4)) & ~OUT_W'(3))
                   - OUT_W'(1);
          d     <= OUT_W'(3);
          sq    <= SQ_W'(9);
        end
      end
      ST_CHECK: begin
        rem <= '0;
        idx <= IDX_W'(OUT_W - 1);
      end
      ST_DIV: begin
        rem <= rem_step;
        idx <= idx - IDX_W'(1);
      end
      ST_EVAL: begin
        if (rem == '0) begin
          // divisor found, move to the next candidate of the progression
          cand <= cand + OUT_W'(4);
          d    <= OUT_W'(3);
          sq   <= SQ_W'(9);
        end else begin
          // (d+2)^2 = d^2 + 4d + 4
          d  <= d + OUT_W'(2);
          sq <= sq + SQ_W'({d, 2'b00}) + SQ_W'(4);
        end
      end
      default: begin
      end
    endcase
  end

`ifndef ASSERT_OFF
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(rsp.valid && req.ready))
    else $error("result offered while taking a new bound");

  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    (req.valid && req.ready) |=> (state == ST_CHECK))
    else $error("accepted bound did not start a search");

  a_cand_mod4: assert property (@(posedge clk) disable iff (rst)
    (state != ST_IDLE) |-> (cand[1:0] == 2'b11))
    else $error("candidate not 3 modulo 4");

  a_div_odd: assert property (@(posedge clk) disable iff (rst)
    (state != ST_IDLE) |-> d[0])
    else $error("trial divisor is even");

  a_rem_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DIV || state == ST_EVAL) |-> (rem < d))
    else $error("partial remainder not below divisor");
`endif

endmodule

FILE: tb/paley_prime_order_search_top_tb.sv
`timescale 1ns / 1ps

module paley_prime_order_search_top_tb;

  localparam int BB               = pps_pkg::BOUND_BITS_DEF;
  localparam int IDLE_PCT         = 22;
  localparam int SINK_HOLD_CYCLES = 400;
  localparam int STALL_LIMIT      = 60000;
  localparam int SETTLE_CYCLES    = 50;
  localparam int REPORT_MAX       = 10;
  localparam int RANDOM_ITEMS     = 270;

  typedef struct packed {
    logic [BB:0] paley_order;
    logic        bound_is_order;
  } paley_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  pps_in_if  #(.BOUND_BITS(BB)) req_if ();
  pps_out_if #(.BOUND_BITS(BB)) rsp_if ();

  paley_prime_order_search_top #(.BOUND_BITS(BB)) dut (
    .clk (clk),
    .rst (rst),
    .req (req_if),
    .rsp (rsp_if)
  );

  paley_result_t order_q[$];
  int            mismatch_count = 0;
  int            stall_cycles   = 0;
  bit            idle_on        = 1'b1;
  int            sink_holds_req  = 0;
  int            sink_holds_done = 0;

  // clock
  always #5 clk = ~clk;

  // smallest prime that is 3 mod 4 and not below the bound
  function automatic paley_result_t next_paley_order(logic [BB-1:0] bound);
    paley_result_t res;
    int unsigned   cand;
    int unsigned   d;
    bit            composite;
    cand = ((int'(bound) + 4) & ~3) - 1;
    forever begin
      composite = 1'b0;
      if (cand >= 4) begin
        if (cand[0] == 1'b0) composite = 1'b1;
        for (d = 3; !composite && d * d <= cand; d += 2) begin
          if (cand % d == 0) composite = 1'b1;
        end
      end
      if (!composite) break;
      cand += 4;
    end
    res.paley_order    = cand[BB:0];
    res.bound_is_order = (cand == int'(bound));
    return res;
  endfunction

  // record expected orders on request beats, check response beats
  always @(posedge clk) begin
    paley_result_t want;
    if (!rst) begin
      if (req_if.valid && req_if.ready)
        order_q.push_back(next_paley_order(req_if.lower_bound));
      if (rsp_if.valid && rsp_if.ready) begin
        if (order_q.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= REPORT_MAX)
            $display("unexpected response beat: order=%0d flag=%0b",
                     rsp_if.paley_order, rsp_if.bound_is_order);
        end else begin
          want = order_q.pop_front();
          if (rsp_if.paley_order !== want.paley_order ||
              rsp_if.bound_is_order !== want.bound_is_order) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_MAX)
              $display("mismatch: expected order=%0d flag=%0b, got order=%0d flag=%0b",
                       want.paley_order, want.bound_is_order,
                       rsp_if.paley_order, rsp_if.bound_is_order);
          end
        end
      end
    end
  end

  // watchdog on cycles with no beat on either channel
  always @(posedge clk) begin
    if (rst || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("paley_prime_order_search_top_tb: FAIL");
        $finish;
      end
    end
  end

  // response side: random idling plus requested long hold-offs
  initial begin
    rsp_if.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (sink_holds_done != sink_holds_req) begin
        rsp_if.ready <= 1'b0;
        repeat (SINK_HOLD_CYCLES) @(posedge clk);
        sink_holds_done++;
      end
      rsp_if.ready <= idle_on ? ($urandom_range(99) >= IDLE_PCT) : 1'b1;
    end
  end

  // offer one bound and wait for its beat; valid is left high
  task automatic send_bound(input logic [BB-1:0] bound);
    while (idle_on && $urandom_range(99) < IDLE_PCT) begin
      req_if.valid <= 1'b0;
      @(posedge clk);
    end
    req_if.valid       <= 1'b1;
    req_if.lower_bound <= bound;
    @(posedge clk);
    while (!req_if.ready) @(posedge clk);
  endtask

  // drop valid and wait for every outstanding order
  task automatic wait_orders_drained();
    req_if.valid <= 1'b0;
    @(posedge clk);
    while (order_q.size() != 0) @(posedge clk);
  endtask

  // field extremes, small bounds, primes on either residue, composites
  task automatic test_directed();
    logic [BB-1:0] bounds[$];
    bounds = '{0, 1, 2, 3, 4, 5, 6, 7, 8, 11, 13, 15, 19, 23, 27, 43,
               255, 1000, 4095, 32767, 32768, 43690, 65519, 65534, 65535};
    foreach (bounds[i]) send_bound(bounds[i]);
    wait_orders_drained();
  endtask

  // no random idling: valid is offered at once and rsp.ready stays high
  task automatic test_back_to_back();
    idle_on = 1'b0;
    repeat (20) send_bound(BB'($urandom_range(511)));
    wait_orders_drained();
    idle_on = 1'b1;
  endtask

  // long response hold-off while further requests wait behind it
  task automatic test_sink_backpressure();
    sink_holds_req++;
    repeat (8) send_bound(BB'($urandom_range(63)));
    wait_orders_drained();
  endtask

  // mostly small bounds, a share over the full field, one drain pause midway
  task automatic test_random();
    int pick;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      pick = $urandom_range(99);
      if (pick < 60)      send_bound(BB'($urandom_range(255)));
      else if (pick < 85) send_bound(BB'($urandom_range(4095)));
      else                send_bound(BB'($urandom_range(2**BB - 1)));
      if (n == RANDOM_ITEMS / 2) wait_orders_drained();
    end
    wait_orders_drained();
  endtask

  initial begin
    req_if.valid       = 1'b0;
    req_if.lower_bound = '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed();
    test_back_to_back();
    test_sink_backpressure();
    test_random();

    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && order_q.size() == 0) begin
      $display("paley_prime_order_search_top_tb: PASS");
    end else begin
      $display("paley_prime_order_search_top_tb: FAIL");
    end
    $finish;
  end

endmodule

FILE: sim.f
hw/rtl/pps_pkg.sv
hw/rtl/pps_in_if.sv
hw/rtl/pps_out_if.sv
hw/rtl/paley_prime_order_search_top.sv
tb/paley_prime_order_search_top_tb.sv
